### rtl/core/ptsg_pkg.sv
package ptsg_pkg;

  localparam int IDX_W      = 12;
  localparam int COORD_W    = 16;
  localparam int LANES      = 3;
  localparam int LIMIT_W    = 16;
  localparam int RATE_W     = 9;
  localparam int LIM2_W     = 2 * LIMIT_W;
  localparam int SQ_W       = 32;
  localparam int DIST2_W    = SQ_W + 2;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int BLEND_W    = RATE_W + 1 + DIFF_W;
  localparam int FRAC_BITS  = 8;

  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 48;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_POINTS_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [RATE_W-1:0]  RATE_ONE    = 9'd256;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 9'd128;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DISTANCE_LIMIT = 1'b0,
    REG_SMOOTHING_RATE = 1'b1
  } reg_idx_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    logic                          in_range;
    logic [IDX_W-1:0]              idx;
    logic                          valid;
    logic [LANES-1:0][COORD_W-1:0] c;      // c[0] = x, c[1] = y, c[2] = z
  } item_t;

  // one stored point; seen is cleared by the sweep after reset
  typedef struct packed {
    logic                          seen;
    logic                          valid;
    logic [LANES-1:0][COORD_W-1:0] c;
  } entry_t;

  typedef struct packed {
    logic [LIM2_W-1:0] lim2;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bkstat_t;

endpackage

### rtl/core/point_temporal_smoother_gated.sv
// Channel  Dir  Group                       Fields (lowest bit up)
// -------  ---  --------------------------  ----------------------------------------
// in       in   s_tvalid s_tready s_tdata    tdata: point_index[11:0] x[27:12]
//                s_tuser                       y[43:28] z[59:44] (pad to 64); tuser: in_valid
// out      out  m_tvalid m_tready m_tdata    tdata: x[15:0] y[31:16] z[47:32];
//                m_tuser                       tuser: out_valid
// config   in   cfg_we cfg_addr cfg_wdata    0: distance_limit, 1: smoothing_rate
//
// One item per cycle sustained while the output is not stalled; a result passes through
// the queue write, memory read into the operand stage, resolve stage and output register.
// An item whose index matches the item one stage ahead waits in the operand stage
// for that entry's write-back. After reset a sweep clears the seen marks of all
// NUM_POINTS entries with s_tready low. A stalled output backs up into the
// queue; s_tready drops only when the queue is full or the sweep is running.
module point_temporal_smoother_gated #(
  parameter int NUM_POINTS  = ptsg_pkg::NUM_POINTS_DEF,
  parameter int QUEUE_DEPTH = ptsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // in: point_index, in_x, in_y, in_z
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ptsg_pkg::S_TDATA_W-1:0]  s_tdata,
  // in_valid
  input  logic                            s_tuser,
  // out: out_x, out_y, out_z
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ptsg_pkg::M_TDATA_W-1:0]  m_tdata,
  // out_valid
  output logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [ptsg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ptsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ptsg_pkg::*;

  logic [LIMIT_W-1:0] distance_limit;
  logic [RATE_W-1:0]  smoothing_rate;
  cfg_t               cfg;

  logic     push;
  item_t    push_item;
  logic     pop;
  item_t    head;
  qstat_t   q_stat;
  bkstat_t  bk_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= LIMIT_RESET;
      smoothing_rate <= RATE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DISTANCE_LIMIT: distance_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_SMOOTHING_RATE: smoothing_rate <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // derived settings: squared limit and the rate clamped to one;
  // registered, so they settle in the cycle after a register write
  always_ff @(posedge clk) begin
    cfg.lim2 <= LIM2_W'(distance_limit) * LIM2_W'(distance_limit);
    cfg.rate <= (smoothing_rate > RATE_ONE) ? RATE_ONE : smoothing_rate;
  end

  // front: accept and classify each item
  ptsg_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .bk_stat   (bk_stat),
    .push      (push),
    .push_item (push_item)
  );

  // queue decouples the front from the point store
  ptsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: read-modify-write of the stored point and the result register
  ptsg_back #(
    .NUM_POINTS (NUM_POINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .bk_stat  (bk_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    bk_stat.clearing |-> !s_tready)
    else $error("item accepted during clearing sweep");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    bk_stat.clearing |-> !m_tvalid && !bk_stat.busy)
    else $error("result pending during clearing sweep");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !q_stat.empty)
    else $error("accepted item missing from queue");
`endif

endmodule

### rtl/core/ptsg_front.sv
module ptsg_front #(
  parameter int NUM_POINTS = ptsg_pkg::NUM_POINTS_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ptsg_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  ptsg_pkg::qstat_t               q_stat,
  input  ptsg_pkg::bkstat_t              bk_stat,
  output logic                           push,
  output ptsg_pkg::item_t                push_item
);
  import ptsg_pkg::*;

  logic [IDX_W-1:0] idx;

  assign idx      = s_tdata[IDX_W-1:0];
  assign s_tready = !q_stat.full && !bk_stat.clearing;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_item.idx      = idx;
    push_item.in_range = (32'(idx) < NUM_POINTS);
    push_item.valid    = s_tuser;
    push_item.c        = s_tdata[IDX_W +: LANES*COORD_W];
  end

endmodule

### rtl/core/ptsg_queue.sv
module ptsg_queue #(
  parameter int DEPTH = ptsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ptsg_pkg::item_t  push_item,
  input  logic             pop,
  output ptsg_pkg::item_t  head,
  output ptsg_pkg::qstat_t q_stat
);
  import ptsg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/ptsg_back.sv
module ptsg_back #(
  parameter int NUM_POINTS = ptsg_pkg::NUM_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ptsg_pkg::cfg_t                 cfg,
  input  ptsg_pkg::item_t                head,
  input  ptsg_pkg::qstat_t               q_stat,
  output logic                           pop,
  output ptsg_pkg::bkstat_t              bk_stat,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptsg_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import ptsg_pkg::*;

  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [IDX_W+AW-1:0] wide;
    wide = {{AW{1'b0}}, i};
    return wide[AW-1:0];
  endfunction

  entry_t  mem [NUM_POINTS];

  // clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // operand stage
  logic    s1_valid;
  item_t   s1_item;
  entry_t  rd_data;

  // most recent write, covers the read-during-write window
  logic    lw_valid;
  logic [AW-1:0] lw_addr;
  entry_t  lw_data;

  // resolve stage
  logic                 s2_valid;
  item_t                s2_item;
  logic                 s2_gate;
  logic [SQ_W-1:0]      s2_sq [LANES];
  logic [BLEND_W-1:0]   s2_bl [LANES];

  // output register
  logic    o_valid;
  entry_t  o_data;

  logic [AW-1:0]        s1_addr;
  logic [AW-1:0]        s2_addr;
  entry_t               s1_entry;
  logic                 s1_gate;
  logic [SQ_W-1:0]      s1_sq [LANES];
  logic [BLEND_W-1:0]   s1_bl [LANES];
  logic                 hazard;
  logic                 s1_go;
  logic                 s2_go;
  logic                 outlier;
  entry_t               res;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  entry_t               mem_wd;

  assign s1_addr = to_addr(s1_item.idx);
  assign s2_addr = to_addr(s2_item.idx);

  // operand stage: pick the stored point, take differences and products
  always_comb begin
    entry_t                mem_e;
    logic signed [DIFF_W-1:0]    d;
    logic signed [2*DIFF_W-1:0]  p;
    logic signed [RATE_W:0]      rate_s;
    logic signed [BLEND_W-1:0]   b;
    mem_e  = (lw_valid && lw_addr == s1_addr) ? lw_data : rd_data;
    rate_s = $signed({1'b0, cfg.rate});
    if (mem_e.seen) begin
      s1_entry = mem_e;
    end else begin
      s1_entry.seen  = 1'b1;
      s1_entry.valid = s1_item.valid;
      s1_entry.c     = s1_item.c;
    end
    s1_gate = s1_item.valid && s1_entry.valid;
    for (int l = 0; l < LANES; l++) begin
      d        = $signed({s1_entry.c[l][COORD_W-1], s1_entry.c[l]})
               - $signed({s1_item.c[l][COORD_W-1], s1_item.c[l]});
      p        = d * d;
      b        = rate_s * d;
      s1_sq[l] = p[SQ_W-1:0];
      s1_bl[l] = b;
    end
  end

  // resolve stage: gate on distance, blend or pass
  always_comb begin
    logic [DIST2_W-1:0]        d2;
    logic signed [BLEND_W-1:0] sh;
    sh      = '0;
    d2      = DIST2_W'(s2_sq[0]) + DIST2_W'(s2_sq[1]) + DIST2_W'(s2_sq[2]);
    outlier = (d2 > DIST2_W'(cfg.lim2));
    res.seen  = 1'b1;
    res.valid = s2_item.valid;
    res.c     = s2_item.c;
    if (s2_item.in_range && s2_gate) begin
      if (outlier) begin
        res.valid = 1'b0;
        res.c     = '0;
      end else begin
        res.valid = 1'b1;
        for (int l = 0; l < LANES; l++) begin
          sh       = $signed(s2_bl[l]) >>> FRAC_BITS;
          res.c[l] = s2_item.c[l] + sh[COORD_W-1:0];
        end
      end
    end
  end

  // hold an item whose entry is still being resolved one stage ahead
  assign hazard = s1_valid && s2_valid && s1_item.in_range && s2_item.in_range
                  && (s1_addr == s2_addr);
  assign s2_go  = s2_valid && (!o_valid || m_tready);
  assign s1_go  = s1_valid && !hazard && (!s2_valid || s2_go);
  assign pop    = !q_stat.empty && !clearing && (!s1_valid || s1_go);

  assign mem_we = clearing || (s2_go && s2_item.in_range);
  assign mem_wa = clearing ? clr_addr : s2_addr;
  assign mem_wd = clearing ? entry_t'('0) : res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[to_addr(head.idx)];
      s1_item <= head;
    end
    if (s1_go) begin
      s2_item <= s1_item;
      s2_gate <= s1_gate;
      s2_sq   <= s1_sq;
      s2_bl   <= s1_bl;
    end
    if (s2_go) begin
      o_data <= res;
    end
    if (s2_go && s2_item.in_range) begin
      lw_addr <= s2_addr;
      lw_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(NUM_POINTS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      if (s2_go && s2_item.in_range) begin
        lw_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid         = o_valid;
  assign m_tdata          = o_data.c;
  assign m_tuser          = o_data.valid;
  assign bk_stat.clearing = clearing;
  assign bk_stat.busy     = s1_valid || s2_valid || o_valid;

endmodule

### test/point_temporal_smoother_gated_tb.sv
`timescale 1ns / 1ps

module point_temporal_smoother_gated_tb;
  import ptsg_pkg::*;

  // one point as it travels in or out: coordinates in mm plus validity
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               valid;
  } point_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata;   // point_index, in_x, in_y, in_z, zero pad
  logic                    s_tuser;   // in_valid
  logic                    m_tvalid;
  logic                    m_tready;
  logic [M_TDATA_W-1:0]    m_tdata;   // out_x, out_y, out_z
  logic                    m_tuser;   // out_valid
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // shadow of the block's registers and per-index memory
  logic [15:0]             dist_limit;
  logic [8:0]              smooth_rate;
  point_t                  stored_pts [4096];
  bit                      visited    [4096];

  // smoothed points still on their way out, oldest first
  point_t                  pending_pts [$];

  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      n_errors;
  int                      n_sent;
  int                      n_checked;
  int                      n_blends;
  int                      n_outliers;
  int                      n_passed;

  point_temporal_smoother_gated uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #(4_000_000);
    $display("FAIL point_temporal_smoother_gated");
    $finish;
  end

  // Q1.8 blend of one lane; taking bits [23:8] of the sum floors toward minus infinity.
  function automatic logic signed [15:0] blend_lane(input logic signed [15:0] last,
                                                    input logic signed [15:0] cur,
                                                    input int unsigned w);
    longint acc;
    acc = longint'(w) * longint'(last) + longint'(256 - w) * longint'(cur);
    return acc[23:8];
  endfunction

  // Work out the output for one accepted point and update the shadow memory.
  function automatic point_t smooth_point(input logic [11:0] idx, input point_t cur);
    point_t      res;
    point_t      last;
    longint      dx;
    longint      dy;
    longint      dz;
    longint      d2;
    longint      lim2;
    int unsigned w;
    res = cur;
    // saturate the rate: anything over one keeps the previous point in full
    w = (smooth_rate > 9'd256) ? 256 : int'(smooth_rate);
    // first visit: seed the entry from the input so a valid point comes out as is
    if (!visited[idx]) begin
      stored_pts[idx] = cur;
      visited[idx] = 1'b1;
    end
    last = stored_pts[idx];
    if (cur.valid && last.valid) begin
      dx = longint'(cur.x) - longint'(last.x);
      dy = longint'(cur.y) - longint'(last.y);
      dz = longint'(cur.z) - longint'(last.z);
      d2 = dx * dx + dy * dy + dz * dz;
      lim2 = longint'(dist_limit) * longint'(dist_limit);
      if (d2 > lim2) begin
        // jump too far: drop the point and poison the entry
        res = '{16'sd0, 16'sd0, 16'sd0, 1'b0};
        n_outliers++;
      end else begin
        res.x = blend_lane(last.x, cur.x, w);
        res.y = blend_lane(last.y, cur.y, w);
        res.z = blend_lane(last.z, cur.z, w);
        res.valid = 1'b1;
        n_blends++;
      end
    end else begin
      n_passed++;
    end
    stored_pts[idx] = res;
    return res;
  endfunction

  function automatic point_t make_pt(input int x, input int y, input int z, input bit v);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    p.valid = v;
    return p;
  endfunction

  // Offset a stored coordinate by up to +/- span and clamp to 16 bits.
  function automatic logic signed [15:0] near_coord(input logic signed [15:0] base,
                                                    input int span);
    int t;
    t = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  // Present one point, holding it until the block takes it, then log its expected output.
  task automatic send_point(input logic [11:0] idx, input point_t pt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'b0000, pt.z, pt.y, pt.x, idx};
    s_tuser = pt.valid;
    do @(posedge clk); while (!s_tready);
    pending_pts.push_back(smooth_point(idx, pt));
    n_sent++;
  endtask

  // Drop valid and wait until every expected point has come out.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(input reg_idx_t r, input int value);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = r;
    cfg_wdata = 16'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (r == REG_DISTANCE_LIMIT) dist_limit = 16'(value);
    else smooth_rate = 9'(value);
  endtask

  // Receiver side: stall at random per the current profile.
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every accepted output with the oldest pending point.
  always @(posedge clk) begin : check_results
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected output item: x=%0d y=%0d z=%0d valid=%0b",
               $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
               $signed(m_tdata[47:32]), m_tuser);
        n_errors++;
      end else begin
        want = pending_pts.pop_front();
        n_checked++;
        if (m_tdata[15:0] !== want.x) begin
          $error("out_x mismatch: expected %0d, got %0d", want.x, $signed(m_tdata[15:0]));
          n_errors++;
        end
        if (m_tdata[31:16] !== want.y) begin
          $error("out_y mismatch: expected %0d, got %0d", want.y, $signed(m_tdata[31:16]));
          n_errors++;
        end
        if (m_tdata[47:32] !== want.z) begin
          $error("out_z mismatch: expected %0d, got %0d", want.z, $signed(m_tdata[47:32]));
          n_errors++;
        end
        if (m_tuser !== want.valid) begin
          $error("out_valid mismatch: expected %0b, got %0b", want.valid, m_tuser);
          n_errors++;
        end
      end
    end
  end

  // First visits pass straight through, valid or not, at the reset settings.
  task automatic test_first_visit();
    send_point(12'd0,    make_pt(100, -200, 300, 1'b1));
    send_point(12'd4095, make_pt(-32768, 32767, -1, 1'b1));
    send_point(12'hAAA,  make_pt(12345, -5, 7, 1'b0));
    send_point(12'h555,  make_pt(-32768, 21845, -21846, 1'b0));
  endtask

  // Blend one index at several rates, including the saturated one above 256.
  task automatic test_blend_rates();
    send_point(12'd0, make_pt(300, -100, 301, 1'b1));
    write_reg(REG_SMOOTHING_RATE, 0);
    send_point(12'd0, make_pt(310, -90, 299, 1'b1));
    write_reg(REG_SMOOTHING_RATE, 256);
    send_point(12'd0, make_pt(320, -80, 295, 1'b1));
    write_reg(REG_SMOOTHING_RATE, 511);
    send_point(12'd0, make_pt(-700, 900, -2000, 1'b1));
    write_reg(REG_SMOOTHING_RATE, 77);
    send_point(12'd0, make_pt(-7, -81, 290, 1'b1));
  endtask

  // Distance gate at the boundary, recovery from a dropped entry, invalid input
  // over a valid entry, and a zero limit. Same index back to back on purpose.
  task automatic test_outlier_gate();
    write_reg(REG_DISTANCE_LIMIT, 100);
    write_reg(REG_SMOOTHING_RATE, 128);
    send_point(12'd5, make_pt(0, 0, 0, 1'b1));
    send_point(12'd5, make_pt(100, 0, 0, 1'b1));    // exactly on the limit: blended
    send_point(12'd5, make_pt(50, 101, 0, 1'b1));   // one past: dropped
    send_point(12'd5, make_pt(7, 8, 9, 1'b1));      // stored entry invalid: passes
    send_point(12'd5, make_pt(1, 2, 3, 1'b0));      // invalid input: passes
    write_reg(REG_DISTANCE_LIMIT, 0);
    send_point(12'd6, make_pt(5, 5, 5, 1'b1));
    send_point(12'd6, make_pt(5, 5, 5, 1'b1));      // no movement still blends
    send_point(12'd6, make_pt(5, 5, 6, 1'b1));      // any movement is dropped
  endtask

  // Full-scale coordinates at the widest limit.
  task automatic test_extremes();
    write_reg(REG_DISTANCE_LIMIT, 65535);
    send_point(12'd4094, make_pt(32767, 0, 0, 1'b1));
    send_point(12'd4094, make_pt(-32768, 0, 0, 1'b1));  // full swing, floors to -1
    send_point(12'd4095, make_pt(32767, -32768, 0, 1'b1)); // beyond limit
  endtask

  // Random points: mostly revisits of a small window of indices with small
  // jumps so the blend and gate paths stay busy; the rest is wide noise.
  task automatic run_random_phase(input int n, input int limit_val, input int rate_val,
                                  input int send_pct, input int recv_pct);
    logic [11:0] idx;
    point_t      cur;
    int          pool_base;
    int          span;
    write_reg(REG_DISTANCE_LIMIT, limit_val);
    write_reg(REG_SMOOTHING_RATE, rate_val);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    pool_base = $urandom_range(0, 4095 - 31);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) idx = 12'($urandom_range(0, 4095));
      else idx = 12'(pool_base + $urandom_range(0, 31));
      cur.valid = ($urandom_range(0, 99) < 85);
      if (visited[idx] && stored_pts[idx].valid && $urandom_range(0, 99) < 70) begin
        // near jump; now and then wide enough to trip the gate
        span = ($urandom_range(0, 4) == 0) ? int'(dist_limit) : int'(dist_limit) / 2;
        cur.x = near_coord(stored_pts[idx].x, span);
        cur.y = near_coord(stored_pts[idx].y, span);
        cur.z = near_coord(stored_pts[idx].z, span);
      end else begin
        cur.x = 16'($urandom);
        cur.y = 16'($urandom);
        cur.z = 16'($urandom);
      end
      send_point(idx, cur);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_DISTANCE_LIMIT;
    cfg_wdata = '0;
    dist_limit = 16'd4000;
    smooth_rate = 9'd128;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_blends = 0;
    n_outliers = 0;
    n_passed = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at full rate, starting from the reset register values
    test_first_visit();
    test_blend_rates();
    test_outlier_gate();
    test_extremes();

    // random part: receiver-heavy idling, then sender-heavy, then none
    run_random_phase(250, 1000,  200, 29, 59);
    run_random_phase(250, 65535, 0,   29, 59);
    run_random_phase(250, 0,     256, 59, 29);
    run_random_phase(250, 300,   511, 59, 29);
    run_random_phase(250, 4000,  128, 0,  0);
    run_random_phase(250, 20000, 37,  0,  0);

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d points over directed and random register settings and three stall profiles;",
             n_sent);
    $display("checked %0d outputs: %0d blended, %0d gated as outliers, %0d passed through.",
             n_checked, n_blends, n_outliers, n_passed);
    if (n_errors == 0 && pending_pts.size() == 0) begin
      $display("PASS point_temporal_smoother_gated");
    end else begin
      $display("FAIL point_temporal_smoother_gated");
    end
    $finish;
  end

endmodule
